// ===== src/dtt_pkg.sv =====
// dtt_pkg: shared types, command codes and helpers for the deadline timer table.
// Used by deadline_timer_table_core; depends on nothing.
`timescale 1ns / 1ps
package dtt_pkg;

	// default table size and register reset
	localparam int unsigned DTT_SLOTS_DEF = 16;
	localparam logic [31:0] ROLLBACK_RESET = 32'd3600000;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// command codes
	localparam logic [2:0] MODE_ADD     = 3'd0;
	localparam logic [2:0] MODE_CANCEL  = 3'd1;
	localparam logic [2:0] MODE_REFRESH = 3'd2;
	localparam logic [2:0] MODE_RESET   = 3'd3;
	localparam logic [2:0] MODE_SCAN    = 3'd4;
	localparam logic [2:0] MODE_QUERY   = 3'd5;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RST2,
		ST_HIT,
		ST_SWEEP,
		ST_FINISH,
		ST_OUT
	} dtt_state_t;

	// base + period, saturating at all ones
	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [31:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {33'b0, b};
		return s[64] ? ALL_ONES : s[63:0];
	endfunction

endpackage

// ===== src/dtt_ram.sv =====
// dtt_ram: generic one-write, one-read RAM with registered read and write-first bypass.
// No dependencies.
`timescale 1ns / 1ps
module dtt_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// a same-cycle write to the read address is passed through
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/deadline_timer_table_core.sv =====
// deadline_timer_table_core: timer slot table with add/cancel/refresh/re-period,
// wait query and ordered expiry scan. Depends on dtt_pkg and dtt_ram.
//
//   channel  dir  handshake         payload
//   s        in   s_tvalid/tready   tuser: mode; tdata: id, period, repeat, restart, now
//   m        out  m_tvalid/tready   tdata: ok, id, expired, wait, notify; tlast: last
//   cfg      in   cfg_we            cfg_wdata: rollback limit (ms)
//
// One command at a time; a single 64-bit compare unit sweeps the slots one per cycle.
// Add and query: decode, a sweep of all slots, finish, output; reset period adds a write before the sweep.
// Cancel, refresh, full-table add, matching or failed reset period, empty scan: decode, then output.
// Scan: decode and a hit pass, then output if nothing expires, else sweep, finish, output per expired slot.
// Reset clears all control state; slot periods and deadlines need no clearing.
// Output stalls hold the sequencer; no new command is taken until the last word leaves.
`timescale 1ns / 1ps
module deadline_timer_table_core
	import dtt_pkg::*;
#(
	parameter int unsigned TIMER_SLOTS = DTT_SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [2:0]   s_tuser,   // [2:0] mode
	input  logic [103:0] s_tdata,   // timer_id[3:0] period_ms[35:4] repeat_flag[36]
	                                // restart[37] now_ms[101:38], zero fill above
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,   // ok[0] result_id[4:1] expired_valid[5]
	                                // wait_ms[69:6] front_notify[70], zero fill above
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata
);
	localparam int unsigned IDXW = $clog2(TIMER_SLOTS);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TIMER_SLOTS - 1);

	dtt_state_t state_q, state_d;

	// latched command
	logic [2:0]  mode_q;
	logic [3:0]  id_q;
	logic [31:0] period_q;
	logic        rep_q, restart_q;
	logic [63:0] now_q;

	// slot flags and global state
	logic [TIMER_SLOTS-1:0] active_q, repeat_q, cand_q;
	logic                   notify_q, rb_q, found_q;
	logic [63:0]            prev_q, best_dl_q, start_q;
	logic [31:0]            limit_q;
	logic [IDXW-1:0]        ptr_q, ptr_d, best_q, target_q;

	// result register
	logic        ok_q, ev_q, fn_q, last_q;
	logic [3:0]  rid_q;
	logic [63:0] wait_q;

	// slot memories
	logic            dl_we, per_we;
	logic [IDXW-1:0] wr_addr;
	logic [63:0]     dl_wd, rd_dl;
	logic [31:0]     rd_per;

	logic                   s_acc, m_acc, inrange, free_any, upd, sweep_end;
	logic [IDXW-1:0]        free_idx, best_next;
	logic [TIMER_SLOTS-1:0] hit_next, cand_left;
	logic [64:0]            lim;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;
	assign inrange = (32'(id_q) < 32'(TIMER_SLOTS));
	assign lim = {1'b0, now_q} + {33'b0, limit_q};

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_any = 1'b1;
				free_idx = IDXW'(i);
			end
		end
	end

	// shared compare unit: one slot per cycle
	assign upd = cand_q[ptr_q] && (!found_q || (rd_dl < best_dl_q));
	assign best_next = upd ? ptr_q : best_q;
	assign sweep_end = (ptr_q == LAST_IDX);
	assign hit_next = cand_q | ((active_q[ptr_q] && (rb_q || rd_dl <= now_q))
		? (TIMER_SLOTS'(1) << ptr_q) : '0);
	assign cand_left = cand_q & ~(TIMER_SLOTS'(1) << ptr_q);

	dtt_ram #(.WIDTH(64), .DEPTH(TIMER_SLOTS)) u_dl (
		.clk(clk), .we(dl_we), .waddr(wr_addr), .wdata(dl_wd),
		.raddr(ptr_d), .rdata(rd_dl)
	);
	dtt_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_per (
		.clk(clk), .we(per_we), .waddr(wr_addr), .wdata(period_q),
		.raddr(ptr_d), .rdata(rd_per)
	);

	// next state and read pointer
	always_comb begin
		state_d = state_q;
		ptr_d = ptr_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					state_d = ST_DECODE;
					ptr_d = IDXW'(s_tdata[3:0]);
				end
			end
			ST_DECODE: begin
				ptr_d = '0;
				priority if (mode_q == MODE_ADD && free_any) begin
					state_d = ST_SWEEP;
				end else if (mode_q == MODE_QUERY) begin
					state_d = ST_SWEEP;
				end else if (mode_q == MODE_SCAN && (|active_q)) begin
					state_d = ST_HIT;
				end else if (mode_q == MODE_RESET && inrange && active_q[ptr_q]
					&& (restart_q || period_q != rd_per)) begin
					state_d = ST_RST2;
					ptr_d = ptr_q;
				end else begin
					state_d = ST_OUT;
					ptr_d = ptr_q;
				end
			end
			ST_RST2: begin
				state_d = ST_SWEEP;
				ptr_d = '0;
			end
			ST_HIT: begin
				ptr_d = ptr_q + 1'b1;
				if (sweep_end) begin
					ptr_d = '0;
					state_d = (|hit_next) ? ST_SWEEP : ST_OUT;
				end
			end
			ST_SWEEP: begin
				ptr_d = ptr_q + 1'b1;
				if (sweep_end) begin
					ptr_d = best_next;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (m_acc) begin
					if (mode_q == MODE_SCAN && (|cand_q)) begin
						state_d = ST_SWEEP;
						ptr_d = '0;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshakes and memory writes
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = (state_q == ST_OUT);
		dl_we = 1'b0;
		per_we = 1'b0;
		wr_addr = ptr_q;
		dl_wd = sat_add(now_q, rd_per);
		unique case (state_q)
			ST_DECODE: begin
				if (mode_q == MODE_ADD && free_any) begin
					dl_we = 1'b1;
					per_we = 1'b1;
					wr_addr = free_idx;
					dl_wd = sat_add(now_q, period_q);
				end else if (mode_q == MODE_REFRESH && inrange && active_q[ptr_q]) begin
					dl_we = 1'b1;
				end
			end
			ST_RST2: begin
				dl_we = 1'b1;
				per_we = 1'b1;
				dl_wd = sat_add(start_q, period_q);
			end
			ST_FINISH: begin
				dl_we = (mode_q == MODE_SCAN) && repeat_q[ptr_q];
			end
			default: ;
		endcase
	end

	assign m_tdata = {1'b0, fn_q, wait_q, ev_q, rid_q, ok_q};
	assign m_tlast = last_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q <= '0;
			active_q <= '0;
			repeat_q <= '0;
			notify_q <= 1'b0;
			prev_q <= '0;
			limit_q <= ROLLBACK_RESET;
		end else begin
			state_q <= state_d;
			ptr_q <= ptr_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_DECODE: begin
					if (mode_q == MODE_ADD && free_any) begin
						active_q[free_idx] <= 1'b1;
						repeat_q[free_idx] <= rep_q;
					end
					if (mode_q == MODE_CANCEL && inrange) begin
						active_q[ptr_q] <= 1'b0;
					end
					if (mode_q == MODE_QUERY) begin
						notify_q <= 1'b0;
					end
					if (mode_q == MODE_SCAN && (|active_q)) begin
						prev_q <= now_q;
					end
				end
				ST_FINISH: begin
					if (mode_q == MODE_SCAN) begin
						if (!repeat_q[ptr_q]) begin
							active_q[ptr_q] <= 1'b0;
						end
					end else if (mode_q != MODE_QUERY && best_q == target_q && !notify_q) begin
						notify_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// command and sweep datapath
	always_ff @(posedge clk) begin
		if (s_acc) begin
			mode_q <= s_tuser;
			id_q <= s_tdata[3:0];
			period_q <= s_tdata[35:4];
			rep_q <= s_tdata[36];
			restart_q <= s_tdata[37];
			now_q <= s_tdata[101:38];
		end
		unique case (state_q)
			ST_DECODE: begin
				ev_q <= 1'b0;
				wait_q <= '0;
				fn_q <= 1'b0;
				last_q <= 1'b1;
				found_q <= 1'b0;
				// add sweeps the new slot too; scan builds its set in the hit pass
				rid_q <= (mode_q == MODE_ADD) ? 4'(free_idx) : '0;
				target_q <= (mode_q == MODE_ADD) ? free_idx : ptr_q;
				cand_q <= (mode_q == MODE_SCAN) ? '0
					: ((mode_q == MODE_ADD) ? (active_q | (TIMER_SLOTS'(1) << free_idx))
					: active_q);
				rb_q <= !lim[64] && (lim[63:0] < prev_q);
				start_q <= restart_q ? now_q : ((rd_dl >= {32'b0, rd_per})
					? (rd_dl - {32'b0, rd_per}) : '0);
				unique case (mode_q)
					MODE_ADD: ok_q <= free_any;
					MODE_CANCEL, MODE_REFRESH: ok_q <= inrange && active_q[ptr_q];
					MODE_RESET: ok_q <= inrange
						&& ((period_q == rd_per && !restart_q) || active_q[ptr_q]);
					MODE_SCAN: ok_q <= 1'b1;
					MODE_QUERY: ok_q <= 1'b1;
					default: ok_q <= 1'b0;
				endcase
			end
			ST_HIT: cand_q <= hit_next;
			ST_SWEEP: begin
				if (upd) begin
					best_dl_q <= rd_dl;
				end
				best_q <= best_next;
				found_q <= found_q || upd;
			end
			ST_FINISH: begin
				unique case (mode_q)
					MODE_SCAN: begin
						cand_q <= cand_left;
						rid_q <= 4'(ptr_q);
						ev_q <= 1'b1;
						last_q <= (cand_left == '0);
					end
					MODE_QUERY: begin
						wait_q <= !found_q ? ALL_ONES
							: ((now_q >= best_dl_q) ? '0 : (best_dl_q - now_q));
					end
					default: fn_q <= (best_q == target_q) && !notify_q;
				endcase
			end
			ST_OUT: begin
				if (m_acc) begin
					found_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	// a result is only shown in the output state, and never while a command is taken
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("output and input open together");
	// a notify result leaves the notify flag raised
	a_notify: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && fn_q) |-> notify_q) else $error("notify without flag");
	// expired ids only come from a scan
	a_expired: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ev_q) |-> (mode_q == MODE_SCAN)) else $error("expiry outside scan");
	// a non-last scan word leaves expired slots pending
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !last_q) |-> (|cand_q)) else $error("scan word without successor");
endmodule
